>>> design/pdrzt_pkg.sv
// ----------------------------------------------------------------------------
// pdrzt_pkg
// Shared types, constants and the zone table for the PWM duty ramp zone timer.
// ----------------------------------------------------------------------------
package pdrzt_pkg;

   localparam int LEVEL_W       = 7;
   localparam int DUTY_MAX      = 100;
   localparam int DUTY_FOLD     = 50;
   localparam int CAP_LIMIT_DEF = 60;
   localparam int ZONE_COUNT    = 7;
   localparam int ZONE_IDX_W    = $clog2(ZONE_COUNT);

   // Duty multiplier held in tenths
   localparam logic [4:0] MULT_X10 = 5'd10;
   localparam logic [4:0] MULT_X12 = 5'd12;
   localparam logic [4:0] MULT_X15 = 5'd15;
   localparam logic [4:0] MULT_X20 = 5'd20;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [LEVEL_W-1:0] target_duty;
   } req_type;

   typedef struct packed {
      logic               output_enable;
      logic [1:0]         prescale_code;
      logic [7:0]         period_top;
      logic [7:0]         compare_value;
      logic               fast_ramp;
      logic               target_reached;
      logic [LEVEL_W-1:0] applied_duty;
   } rsp_type;

   typedef struct packed {
      logic [5:0] fold_max;
      logic [1:0] presc;
      logic [7:0] top;
      logic [4:0] mult10;
   } zone_type;

   localparam zone_type ZONE_TAB [ZONE_COUNT] = '{
      '{fold_max: 6'd1,  presc: 2'd0, top: 8'd199, mult10: MULT_X20},
      '{fold_max: 6'd3,  presc: 2'd1, top: 8'd199, mult10: MULT_X20},
      '{fold_max: 6'd7,  presc: 2'd1, top: 8'd99,  mult10: MULT_X10},
      '{fold_max: 6'd13, presc: 2'd2, top: 8'd199, mult10: MULT_X20},
      '{fold_max: 6'd14, presc: 2'd2, top: 8'd149, mult10: MULT_X15},
      '{fold_max: 6'd15, presc: 2'd2, top: 8'd119, mult10: MULT_X12},
      '{fold_max: 6'd50, presc: 2'd2, top: 8'd99,  mult10: MULT_X10}
   };

endpackage

>>> design/pdrzt_zone.sv
// ----------------------------------------------------------------------------
// pdrzt_zone
// Folds the applied duty about 50, picks its zone and derives timer settings.
// ----------------------------------------------------------------------------
module pdrzt_zone (
   input  logic [pdrzt_pkg::LEVEL_W-1:0] duty,
   output logic                          output_enable,
   output logic [1:0]                    prescale_code,
   output logic [7:0]                    period_top,
   output logic [7:0]                    compare_value
);
   import pdrzt_pkg::*;

   logic [LEVEL_W-1:0]    fold;
   logic [ZONE_IDX_W-1:0] zone_idx;
   logic [9:0]            scaled;     // floor(duty * mult / 10), at most 200
   logic [9:0]            six_d;      // 6 * duty
   logic [23:0]           recip_prod;
   zone_type              zone;

   assign fold = (duty > LEVEL_W'(DUTY_FOLD)) ? LEVEL_W'(DUTY_MAX) - duty : duty;

   // Lowest matching zone wins; last zone catches everything else
   always_comb begin
      zone_idx = ZONE_IDX_W'(ZONE_COUNT - 1);
      for (int i = ZONE_COUNT - 2; i >= 0; i--) begin
         if ({1'b0, fold[5:0]} <= {1'b0, ZONE_TAB[i].fold_max} && fold[6] == 1'b0) begin
            zone_idx = ZONE_IDX_W'(i);
         end
      end
   end

   assign zone = ZONE_TAB[zone_idx];

   // x / 5 as (x * 13108) >> 16, exact for x up to 600
   assign six_d      = {duty, 1'b0} + {duty, 2'b00};
   assign recip_prod = 24'(six_d) * 24'd13108;

   always_comb begin
      case (zone.mult10)
         MULT_X20: scaled = {2'b00, duty, 1'b0};
         MULT_X15: scaled = 10'(duty) + 10'(duty[LEVEL_W-1:1]);
         MULT_X12: scaled = 10'(recip_prod[23:16]);
         MULT_X10: scaled = 10'(duty);
         default:  scaled = 10'(duty);
      endcase
   end

   assign output_enable = (duty != '0);
   assign prescale_code = zone.presc;
   assign period_top    = zone.top;

   always_comb begin
      if (duty == '0 || scaled == '0) begin
         compare_value = 8'd0;
      end else if (scaled > 10'd256) begin
         compare_value = 8'd255;
      end else begin
         compare_value = 8'(scaled - 10'd1);
      end
   end

endmodule

>>> design/pwm_duty_ramp_zone_timer.sv
// ----------------------------------------------------------------------------
// pwm_duty_ramp_zone_timer
// Duty ramp toward a target with zone-based PWM timer settings.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: req_valid / req_stall / req_data. An item is either a new
//   target duty (cmd = load) or a ramp tick (cmd = tick). Each accepted item
//   produces exactly one rsp item carrying the timer settings for the
//   applied duty after that item.
//   csr channel: csr_wr_en / csr_wr_data writes supply_cap_mode; write only
//   while the block is idle.
//   The ramp state updates at the accepting edge and the result lands in the
//   rsp register at the same edge.
//   Throughput: one item per cycle while no waiting result is stalled; the
//   ramp step, zone match and the small constant multiply all sit between
//   the state registers and the rsp register.
//   Stall: when rsp_stall holds a waiting result, req_stall rises and no
//   new item is taken; otherwise a new item is taken while the old result
//   is handed off in the same cycle.
//   Reset: synchronous, active high. Ramp state, flags, cap mode and rsp
//   valid clear; applied duty starts at zero.
// ----------------------------------------------------------------------------
module pwm_duty_ramp_zone_timer #(
   parameter int CAP_LIMIT = pdrzt_pkg::CAP_LIMIT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pdrzt_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pdrzt_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);
   import pdrzt_pkg::*;

   localparam logic [LEVEL_W-1:0] CapLevel = LEVEL_W'(CAP_LIMIT);
   localparam logic [LEVEL_W-1:0] MaxLevel = LEVEL_W'(DUTY_MAX);

   logic               cap_mode_ff;
   logic [LEVEL_W-1:0] throttle_ff, throttle_in;
   logic [LEVEL_W-1:0] applied_ff,  applied_in;
   logic [LEVEL_W-1:0] goal_ff,     goal_in;
   logic               reached_ff,  reached_in;
   logic               ramp_up_ff,  ramp_up_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff,      rsp_in;
   logic               accept;

   logic               zone_oe;
   logic [1:0]         zone_presc;
   logic [7:0]         zone_top;
   logic [7:0]         zone_cmp;

   // Output register frees up when empty or being taken this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Ramp / load next state
   always_comb begin
      throttle_in = throttle_ff;
      applied_in  = applied_ff;
      goal_in     = goal_ff;
      reached_in  = reached_ff;
      ramp_up_in  = ramp_up_ff;
      if (req_data.cmd == CMD_LOAD) begin
         goal_in    = (req_data.target_duty > MaxLevel) ? MaxLevel : req_data.target_duty;
         reached_in = 1'b0;
      end else begin
         if (!reached_ff) begin
            if (applied_ff < goal_ff) begin
               if (throttle_ff < MaxLevel) begin
                  throttle_in = throttle_ff + LEVEL_W'(1);
               end
               ramp_up_in = 1'b1;
            end else if (applied_ff > goal_ff) begin
               if (throttle_ff != '0) begin
                  throttle_in = throttle_ff - LEVEL_W'(1);
               end
               ramp_up_in = 1'b0;
            end else begin
               reached_in = 1'b1;
            end
         end
         // Capped supply: applied duty follows the throttle only while it is below the cap limit
         if (!cap_mode_ff || throttle_in < CapLevel) begin
            applied_in = throttle_in;
         end
      end
   end

   pdrzt_zone u_zone (
      .duty          (applied_in),
      .output_enable (zone_oe),
      .prescale_code (zone_presc),
      .period_top    (zone_top),
      .compare_value (zone_cmp)
   );

   always_comb begin
      rsp_in.output_enable  = zone_oe;
      rsp_in.prescale_code  = zone_presc;
      rsp_in.period_top     = zone_top;
      rsp_in.compare_value  = zone_cmp;
      rsp_in.fast_ramp      = ramp_up_in;
      rsp_in.target_reached = reached_in;
      rsp_in.applied_duty   = applied_in;
   end

   // Control and ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_mode_ff  <= 1'b0;
         throttle_ff  <= '0;
         applied_ff   <= '0;
         goal_ff      <= '0;
         reached_ff   <= 1'b0;
         ramp_up_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_mode_ff <= csr_wr_data;
         end
         if (accept) begin
            throttle_ff  <= throttle_in;
            applied_ff   <= applied_in;
            goal_ff      <= goal_in;
            reached_ff   <= reached_in;
            ramp_up_ff   <= ramp_up_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
